@@ src/tajcs_pkg.sv @@
package tajcs_pkg;

	localparam int SPAN_BITS_DEF = 16;
	localparam int OUT_SPAN_W = 16;
	localparam int BACKOFF_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [2:0] CMD_JOG_XP = 3'd0;
	localparam logic [2:0] CMD_JOG_XN = 3'd1;
	localparam logic [2:0] CMD_JOG_YP = 3'd2;
	localparam logic [2:0] CMD_JOG_YN = 3'd3;
	localparam logic [2:0] CMD_CENTER = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_JOG_BACKOFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_X_BACKOFF = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_BACKOFF = 2'd2;

	localparam logic [BACKOFF_W-1:0] JOG_BACKOFF_RST = 8'd40;
	localparam logic [BACKOFF_W-1:0] X_BACKOFF_RST = 8'd40;
	localparam logic [BACKOFF_W-1:0] Y_BACKOFF_RST = 8'd80;

	typedef struct packed {
		logic       mode;
		logic [2:0] command;
		logic       limit_x_clear;
		logic       limit_y_clear;
	} item_t;

	typedef struct packed {
		logic                  step_x;
		logic                  step_y;
		logic                  dir_x;
		logic                  dir_y;
		logic                  busy_res;
		logic                  done_res;
		logic [OUT_SPAN_W-1:0] span_x;
		logic [OUT_SPAN_W-1:0] span_y;
	} res_t;

	typedef struct packed {
		logic [BACKOFF_W-1:0] jog_backoff;
		logic [BACKOFF_W-1:0] x_backoff;
		logic [BACKOFF_W-1:0] y_backoff;
	} cfg_t;

endpackage

@@ src/tajcs_if.sv @@
interface tajcs_item_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [2:0] command;
	logic       limit_x_clear;
	logic       limit_y_clear;

	modport source (output valid, mode, command, limit_x_clear, limit_y_clear, input ready);
	modport sink (input valid, mode, command, limit_x_clear, limit_y_clear, output ready);
endinterface

interface tajcs_result_if;
	logic        valid;
	logic        ready;
	logic        step_x;
	logic        step_y;
	logic        dir_x;
	logic        dir_y;
	logic        busy_res;
	logic        done_res;
	logic [15:0] span_x;
	logic [15:0] span_y;

	modport source (output valid, step_x, step_y, dir_x, dir_y, busy_res, done_res,
		span_x, span_y, input ready);
	modport sink (input valid, step_x, step_y, dir_x, dir_y, busy_res, done_res,
		span_x, span_y, output ready);
endinterface

@@ src/tajcs_cfg.sv @@
module tajcs_cfg
	import tajcs_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] idx,
	input  logic [BACKOFF_W-1:0] data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jog_backoff <= JOG_BACKOFF_RST;
			cfg_q.x_backoff   <= X_BACKOFF_RST;
			cfg_q.y_backoff   <= Y_BACKOFF_RST;
		end else if (wr_en) begin
			case (idx)
				CFG_JOG_BACKOFF: cfg_q.jog_backoff <= data;
				CFG_X_BACKOFF:   cfg_q.x_backoff <= data;
				CFG_Y_BACKOFF:   cfg_q.y_backoff <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ src/tajcs_core.sv @@
module tajcs_core
	import tajcs_pkg::*;
#(
	parameter int SPAN_BITS = SPAN_BITS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  item_t item,
	input  cfg_t  cfg,
	output res_t  res
);

	localparam int CW = SPAN_BITS - 1;
	localparam logic [SPAN_BITS-1:0] SPAN_MAX = '1;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_JOG_STEP  = 4'd1,
		PH_JOG_CHECK = 4'd2,
		PH_JOG_BACK  = 4'd3,
		PH_SEEK_XP   = 4'd4,
		PH_BACK_XP   = 4'd5,
		PH_SEEK_XN   = 4'd6,
		PH_BACK_XN   = 4'd7,
		PH_SEEK_YP   = 4'd8,
		PH_BACK_YP   = 4'd9,
		PH_SEEK_YN   = 4'd10,
		PH_BACK_YN   = 4'd11,
		PH_MID_X     = 4'd12,
		PH_MID_Y     = 4'd13
	} phase_t;

	phase_t               phase_q, ph_n;
	logic [1:0]           jad_q, jad_n;
	logic [BACKOFF_W-1:0] back_q, back_n;
	logic [SPAN_BITS-1:0] tx_q, tx_n, ty_q, ty_n;
	logic [CW-1:0]        cc_q, cc_n;
	logic                 dirx_q, dirx_n, diry_q, diry_n;
	logic                 stx, sty, done, ent;
	logic                 axis, plus, clr;
	logic [31:0]          tx_ext, ty_ext;

	always_comb begin
		ph_n   = phase_q;
		jad_n  = jad_q;
		back_n = back_q;
		tx_n   = tx_q;
		ty_n   = ty_q;
		cc_n   = cc_q;
		dirx_n = dirx_q;
		diry_n = diry_q;
		stx    = 1'b0;
		sty    = 1'b0;
		done   = 1'b0;
		ent    = 1'b0;
		axis   = jad_q[1];
		plus   = ~jad_q[0];
		clr    = axis ? item.limit_y_clear : item.limit_x_clear;

		if (item.mode) begin
			if (phase_q == PH_IDLE) begin
				if (item.command == CMD_JOG_XP || item.command == CMD_JOG_XN ||
					item.command == CMD_JOG_YP || item.command == CMD_JOG_YN) begin
					jad_n = item.command[1:0];
					ph_n  = PH_JOG_STEP;
				end else if (item.command == CMD_CENTER) begin
					ph_n = PH_SEEK_XP;
				end
			end
		end else begin
			case (phase_q)
				PH_IDLE: ;
				PH_JOG_STEP: begin
					if (!axis) begin
						stx = 1'b1; dirx_n = plus;
					end else begin
						sty = 1'b1; diry_n = plus;
					end
					ph_n = PH_JOG_CHECK;
				end
				PH_JOG_CHECK: begin
					ent  = 1'b1;
					ph_n = clr ? PH_IDLE : PH_JOG_BACK;
				end
				PH_JOG_BACK: begin
					if (!axis) begin
						stx = 1'b1; dirx_n = ~plus;
					end else begin
						sty = 1'b1; diry_n = ~plus;
					end
					back_n = back_q - 1'b1;
					if (back_n == '0) begin
						ent = 1'b1; ph_n = PH_IDLE;
					end
				end
				PH_SEEK_XP: begin
					if (item.limit_x_clear) begin
						stx = 1'b1; dirx_n = 1'b1;
					end else begin
						ent = 1'b1; ph_n = PH_BACK_XP;
					end
				end
				PH_BACK_XP: begin
					stx = 1'b1; dirx_n = 1'b0;
					back_n = back_q - 1'b1;
					if (back_n == '0) begin
						ent = 1'b1; ph_n = PH_SEEK_XN;
					end
				end
				PH_SEEK_XN: begin
					if (item.limit_x_clear) begin
						stx = 1'b1; dirx_n = 1'b0;
						if (tx_q != SPAN_MAX) tx_n = tx_q + 1'b1;
					end else begin
						ent = 1'b1; ph_n = PH_BACK_XN;
					end
				end
				PH_BACK_XN: begin
					stx = 1'b1; dirx_n = 1'b1;
					back_n = back_q - 1'b1;
					if (back_n == '0) begin
						ent = 1'b1; ph_n = PH_SEEK_YP;
					end
				end
				PH_SEEK_YP: begin
					if (item.limit_y_clear) begin
						sty = 1'b1; diry_n = 1'b1;
					end else begin
						ent = 1'b1; ph_n = PH_BACK_YP;
					end
				end
				PH_BACK_YP: begin
					sty = 1'b1; diry_n = 1'b0;
					back_n = back_q - 1'b1;
					if (back_n == '0) begin
						ent = 1'b1; ph_n = PH_SEEK_YN;
					end
				end
				PH_SEEK_YN: begin
					if (item.limit_y_clear) begin
						sty = 1'b1; diry_n = 1'b0;
						if (ty_q != SPAN_MAX) ty_n = ty_q + 1'b1;
					end else begin
						ent = 1'b1; ph_n = PH_BACK_YN;
					end
				end
				PH_BACK_YN: begin
					sty = 1'b1; diry_n = 1'b1;
					back_n = back_q - 1'b1;
					if (back_n == '0) begin
						ent = 1'b1; ph_n = PH_MID_X;
					end
				end
				PH_MID_X: begin
					stx = 1'b1; dirx_n = 1'b1;
					cc_n = cc_q - 1'b1;
					if (cc_n == '0) begin
						ent = 1'b1; ph_n = PH_MID_Y;
					end
				end
				PH_MID_Y: begin
					sty = 1'b1; diry_n = 1'b1;
					cc_n = cc_q - 1'b1;
					if (cc_n == '0) begin
						ent = 1'b1; ph_n = PH_IDLE;
					end
				end
				default: ph_n = PH_IDLE;
			endcase
		end

		// resolve phase entry, skipping empty moves in chain order
		if (ent && ph_n == PH_JOG_BACK) begin
			back_n = cfg.jog_backoff;
			if (back_n == '0) ph_n = PH_IDLE;
		end
		if (ent && ph_n == PH_BACK_XP) begin
			back_n = cfg.x_backoff;
			if (back_n == '0) ph_n = PH_SEEK_XN;
		end
		if (ent && ph_n == PH_SEEK_XN) tx_n = '0;
		if (ent && ph_n == PH_BACK_XN) begin
			back_n = cfg.x_backoff;
			if (back_n == '0) ph_n = PH_SEEK_YP;
		end
		if (ent && ph_n == PH_BACK_YP) begin
			back_n = cfg.y_backoff;
			if (back_n == '0) ph_n = PH_SEEK_YN;
		end
		if (ent && ph_n == PH_SEEK_YN) ty_n = '0;
		if (ent && ph_n == PH_BACK_YN) begin
			back_n = cfg.y_backoff;
			if (back_n == '0) ph_n = PH_MID_X;
		end
		if (ent && ph_n == PH_MID_X) begin
			cc_n = tx_n[SPAN_BITS-1:1];
			if (cc_n == '0) ph_n = PH_MID_Y;
		end
		if (ent && ph_n == PH_MID_Y) begin
			cc_n = ty_n[SPAN_BITS-1:1];
			if (cc_n == '0) ph_n = PH_IDLE;
		end
		if (ent && ph_n == PH_IDLE) done = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			jad_q   <= '0;
			back_q  <= '0;
			tx_q    <= '0;
			ty_q    <= '0;
			cc_q    <= '0;
			dirx_q  <= 1'b0;
			diry_q  <= 1'b0;
		end else if (adv) begin
			phase_q <= ph_n;
			jad_q   <= jad_n;
			back_q  <= back_n;
			tx_q    <= tx_n;
			ty_q    <= ty_n;
			cc_q    <= cc_n;
			dirx_q  <= dirx_n;
			diry_q  <= diry_n;
		end
	end

	assign tx_ext = 32'(tx_n);
	assign ty_ext = 32'(ty_n);

	always_comb begin
		res.step_x   = stx;
		res.step_y   = sty;
		res.dir_x    = dirx_n;
		res.dir_y    = diry_n;
		res.busy_res = (ph_n != PH_IDLE);
		res.done_res = done;
		res.span_x   = tx_ext[OUT_SPAN_W-1:0];
		res.span_y   = ty_ext[OUT_SPAN_W-1:0];
	end

endmodule

@@ src/two_axis_jog_and_centering_sequencer_top.sv @@
// Two-axis jog and centering step sequencer.
// item channel: each transaction is either a command (mode 1) or a step tick
// (mode 0) carrying both limit switch levels. A command is taken only while
// idle and is dropped while a sequence runs. Each tick yields at most one step
// per axis plus the held direction levels.
// result channel: exactly one transaction per item transaction: step pulses,
// direction levels, busy/done flags and the last counted X and Y spans.
// cfg port: write jog, X and Y backoff step counts while idle.
// Throughput: one item per cycle while the receiver takes results. Each item passes
// an input register and then a result register before its result is offered.
// The whole per-item update is one pass of the sequencer logic between those
// two registers.
// Reset: sequencer idle, counters, spans and direction levels zero, backoff
// counts back to 40 / 40 / 80. No items are lost or repeated at reset exit.
// Receiver stall: the result register holds its transaction; one more item
// may sit in the input register, then ready drops until the result is taken.
module two_axis_jog_and_centering_sequencer_top
	import tajcs_pkg::*;
#(
	parameter int SPAN_BITS = SPAN_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	tajcs_item_if.sink           item,
	tajcs_result_if.source       result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [BACKOFF_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item_s1;
	logic  vld_s1;
	res_t  res, res_s2;
	logic  vld_s2;
	logic  adv;

	tajcs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.idx    (cfg_idx),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tajcs_core #(.SPAN_BITS(SPAN_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign adv        = vld_s1 && (!vld_s2 || result.ready);
	assign item.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.mode          <= item.mode;
			item_s1.command       <= item.command;
			item_s1.limit_x_clear <= item.limit_x_clear;
			item_s1.limit_y_clear <= item.limit_y_clear;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (result.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res;
	end

	assign result.valid    = vld_s2;
	assign result.step_x   = res_s2.step_x;
	assign result.step_y   = res_s2.step_y;
	assign result.dir_x    = res_s2.dir_x;
	assign result.dir_y    = res_s2.dir_y;
	assign result.busy_res = res_s2.busy_res;
	assign result.done_res = res_s2.done_res;
	assign result.span_x   = res_s2.span_x;
	assign result.span_y   = res_s2.span_y;

endmodule
